// ===== rtl/e2q_pkg.sv =====
// Shared types, constants and helper functions of the Euler-to-quaternion converter.
package e2q_pkg;

  localparam int NUM_ANGLES = 3;
  localparam int CW         = 34;
  localparam int ATAN_LEN   = 24;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [CW-1:0] NEG_HALF_PI_Q30 = -34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30          = 34'sd3373259426;
  localparam logic signed [CW-1:0] NEG_PI_Q30      = -34'sd3373259426;
  localparam logic signed [CW-1:0] SC_ROUND        = 34'sd32768;
  localparam logic signed [17:0]   SC_ONE          = 18'sd16384;
  localparam logic signed [17:0]   SC_NEG_ONE      = -18'sd16384;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_lane_t;

  typedef cordic_lane_t [NUM_ANGLES-1:0] cordic_vec_t;

  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } sincos_t;

  typedef sincos_t [NUM_ANGLES-1:0] sincos_vec_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

  // Round Q2.30 to nearest Q1.14 (ties up) and clamp to plus or minus one
  function automatic logic signed [15:0] round_unit(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [17:0]   r;
    t = v + SC_ROUND;
    r = t[CW-1:16];
    if (r > SC_ONE) begin
      r = SC_ONE;
    end else if (r < SC_NEG_ONE) begin
      r = SC_NEG_ONE;
    end
    return r[15:0];
  endfunction

endpackage

// ===== rtl/e2q_cordic_stage.sv =====
// One registered CORDIC rotation stage, three angle lanes side by side.
module e2q_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  e2q_pkg::cordic_vec_t data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output e2q_pkg::cordic_vec_t data_o
);

  localparam logic signed [e2q_pkg::CW-1:0] ATAN = e2q_pkg::atan_q30(5'(STAGE));

  logic                 valid_q;
  e2q_pkg::cordic_vec_t data_d, data_q;

  always_comb begin
    for (int l = 0; l < e2q_pkg::NUM_ANGLES; l++) begin
      data_d[l].flip = data_i[l].flip;
      if (!data_i[l].z[e2q_pkg::CW-1]) begin
        data_d[l].x = data_i[l].x - (data_i[l].y >>> STAGE);
        data_d[l].y = data_i[l].y + (data_i[l].x >>> STAGE);
        data_d[l].z = data_i[l].z - ATAN;
      end else begin
        data_d[l].x = data_i[l].x + (data_i[l].y >>> STAGE);
        data_d[l].y = data_i[l].y - (data_i[l].x >>> STAGE);
        data_d[l].z = data_i[l].z + ATAN;
      end
    end
  end

  // hold while full and the next stage stalls
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/e2q_sincos.sv =====
// Half-angle fold, CORDIC stage chain and sine/cosine rounding for three angles.
module e2q_sincos #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  e2q_pkg::angles_t     data_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output e2q_pkg::sincos_vec_t data_o
);

  logic                 prep_valid_q;
  e2q_pkg::cordic_vec_t prep_d, prep_q;

  logic                 [CORDIC_STAGES:0] chain_valid;
  logic                 [CORDIC_STAGES:0] chain_stall;
  e2q_pkg::cordic_vec_t [CORDIC_STAGES:0] chain_data;

  logic                 round_valid_q;
  logic                 round_stall;
  e2q_pkg::sincos_vec_t round_d, round_q;

  logic signed [15:0]   angle [e2q_pkg::NUM_ANGLES];

  assign angle[0] = data_i.roll_angle;
  assign angle[1] = data_i.pitch_angle;
  assign angle[2] = data_i.yaw_angle;

  // halve into Q2.30 and fold past plus or minus pi/2
  always_comb begin
    for (int l = 0; l < e2q_pkg::NUM_ANGLES; l++) begin
      logic signed [e2q_pkg::CW-1:0] z0;
      z0 = $signed({{2{angle[l][15]}}, angle[l], 16'b0});
      prep_d[l].x = e2q_pkg::CORDIC_GAIN_Q30;
      prep_d[l].y = '0;
      if (z0 > e2q_pkg::HALF_PI_Q30) begin
        prep_d[l].z    = e2q_pkg::PI_Q30 - z0;
        prep_d[l].flip = 1'b1;
      end else if (z0 < e2q_pkg::NEG_HALF_PI_Q30) begin
        prep_d[l].z    = e2q_pkg::NEG_PI_Q30 - z0;
        prep_d[l].flip = 1'b1;
      end else begin
        prep_d[l].z    = z0;
        prep_d[l].flip = 1'b0;
      end
    end
  end

  assign stall_o = prep_valid_q && chain_stall[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (!stall_o) begin
      prep_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      prep_q <= prep_d;
    end
  end

  assign chain_valid[0] = prep_valid_q;
  assign chain_data[0]  = prep_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    e2q_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .stall_o (chain_stall[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .stall_i (chain_stall[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  assign chain_stall[CORDIC_STAGES] = round_stall;

  // negate the cosine of a folded angle, then round both to Q1.14
  always_comb begin
    for (int l = 0; l < e2q_pkg::NUM_ANGLES; l++) begin
      logic signed [e2q_pkg::CW-1:0] xc;
      xc = chain_data[CORDIC_STAGES][l].flip ? -chain_data[CORDIC_STAGES][l].x
                                              : chain_data[CORDIC_STAGES][l].x;
      round_d[l].c = e2q_pkg::round_unit(xc);
      round_d[l].s = e2q_pkg::round_unit(chain_data[CORDIC_STAGES][l].y);
    end
  end

  assign round_stall = round_valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_valid_q <= 1'b0;
    end else if (!round_stall) begin
      round_valid_q <= chain_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!round_stall && chain_valid[CORDIC_STAGES]) begin
      round_q <= round_d;
    end
  end

  assign valid_o = round_valid_q;
  assign data_o  = round_q;

endmodule

// ===== rtl/e2q_combine.sv =====
// Three-stage product and sum pipeline that forms the rounded quaternion.
module e2q_combine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  e2q_pkg::sincos_vec_t data_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output e2q_pkg::quat_t       data_o
);

  localparam logic signed [48:0] SUM_ROUND = 49'sd134217728;
  localparam logic signed [20:0] Q_ONE     = 21'sd16384;
  localparam logic signed [20:0] Q_NEG_ONE = -21'sd16384;

  typedef struct packed {
    logic signed [31:0] c1c2;
    logic signed [31:0] s1s2;
    logic signed [31:0] c1s2;
    logic signed [31:0] s1c2;
    logic signed [15:0] s3;
    logic signed [15:0] c3;
  } pairs_t;

  typedef struct packed {
    logic signed [47:0] w_a;
    logic signed [47:0] w_b;
    logic signed [47:0] x_a;
    logic signed [47:0] x_b;
    logic signed [47:0] y_a;
    logic signed [47:0] y_b;
    logic signed [47:0] z_a;
    logic signed [47:0] z_b;
  } terms_t;

  function automatic logic signed [15:0] finish(input logic signed [48:0] sum);
    logic signed [48:0] t;
    logic signed [20:0] r;
    t = sum + SUM_ROUND;
    r = t[48:28];
    if (r > Q_ONE) begin
      r = Q_ONE;
    end else if (r < Q_NEG_ONE) begin
      r = Q_NEG_ONE;
    end
    return r[15:0];
  endfunction

  logic           pair_valid_q, term_valid_q, out_valid_q;
  logic           pair_stall, term_stall, out_stall;
  pairs_t         pair_d, pair_q;
  terms_t         term_d, term_q;
  e2q_pkg::quat_t out_d, out_q;

  // roll and pitch pairs
  always_comb begin
    pair_d.c1c2 = 32'(data_i[0].c) * 32'(data_i[1].c);
    pair_d.s1s2 = 32'(data_i[0].s) * 32'(data_i[1].s);
    pair_d.c1s2 = 32'(data_i[0].c) * 32'(data_i[1].s);
    pair_d.s1c2 = 32'(data_i[0].s) * 32'(data_i[1].c);
    pair_d.s3   = data_i[2].s;
    pair_d.c3   = data_i[2].c;
  end

  // bring in yaw
  always_comb begin
    term_d.w_a = 48'(pair_q.c1c2) * 48'(pair_q.c3);
    term_d.w_b = 48'(pair_q.s1s2) * 48'(pair_q.s3);
    term_d.x_a = 48'(pair_q.s1c2) * 48'(pair_q.c3);
    term_d.x_b = 48'(pair_q.c1s2) * 48'(pair_q.s3);
    term_d.y_a = 48'(pair_q.c1s2) * 48'(pair_q.c3);
    term_d.y_b = 48'(pair_q.s1c2) * 48'(pair_q.s3);
    term_d.z_a = 48'(pair_q.c1c2) * 48'(pair_q.s3);
    term_d.z_b = 48'(pair_q.s1s2) * 48'(pair_q.c3);
  end

  always_comb begin
    out_d.quat_w = finish(49'(term_q.w_a) + 49'(term_q.w_b));
    out_d.quat_x = finish(49'(term_q.x_a) - 49'(term_q.x_b));
    out_d.quat_y = finish(49'(term_q.y_a) + 49'(term_q.y_b));
    out_d.quat_z = finish(49'(term_q.z_a) - 49'(term_q.z_b));
  end

  assign out_stall  = out_valid_q && stall_i;
  assign term_stall = term_valid_q && out_stall;
  assign pair_stall = pair_valid_q && term_stall;
  assign stall_o    = pair_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_valid_q <= 1'b0;
      term_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (!pair_stall) begin
        pair_valid_q <= valid_i;
      end
      if (!term_stall) begin
        term_valid_q <= pair_valid_q;
      end
      if (!out_stall) begin
        out_valid_q <= term_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pair_stall && valid_i) begin
      pair_q <= pair_d;
    end
    if (!term_stall && pair_valid_q) begin
      term_q <= term_d;
    end
    if (!out_stall && term_valid_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/euler_angles_to_quaternion.sv =====
// One transfer per cycle while in_stall_o is low; every stage has its own valid bit, so bubbles
// close up and a stalled output does not block input until the pipeline is full.
// Depth is set by the CORDIC stage chain, one rotation per register stage.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module euler_angles_to_quaternion #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  e2q_pkg::angles_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output e2q_pkg::quat_t   out_data_o
);

  logic                 sc_valid;
  logic                 sc_stall;
  e2q_pkg::sincos_vec_t sc_data;

  e2q_sincos #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (sc_valid),
    .stall_i (sc_stall),
    .data_o  (sc_data)
  );

  e2q_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .stall_o (sc_stall),
    .data_i  (sc_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the Euler-angle to quaternion converter.
`timescale 1ns / 1ps

module tb;

  localparam int     STAGES      = 16;
  localparam int     LATENCY     = STAGES + 5;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     HOLD_CYCLES = 300;
  localparam int     PHASE_ITEMS = 170;
  localparam int     ANGLE_MAX   = 25736;

  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint UNIT_Q14    = 64'sd16384;

  typedef struct packed {
    e2q_pkg::angles_t ang;
    logic             typed;
    e2q_pkg::quat_t   quat;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  e2q_pkg::angles_t in_data;
  logic             out_valid;
  logic             out_stall;
  e2q_pkg::quat_t   out_data;

  e2q_pkg::quat_t quat_expect_q[$];
  stim_row_t      directed_rows[$];
  longint         atan_tab[24];

  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  euler_angles_to_quaternion #(
    .CORDIC_STAGES(STAGES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint clamp_q14(input longint v);
    if (v > UNIT_Q14) return UNIT_Q14;
    if (v < -UNIT_Q14) return -UNIT_Q14;
    return v;
  endfunction

  // sine and cosine in Q1.14 of half a Q3.13 angle
  task automatic half_angle_trig(input logic signed [15:0] ang,
                                 output longint sn, output longint cs);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    z    = longint'(ang) * 65536;
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    // fold half-angles beyond a quarter turn back into CORDIC range
    if (z > HALF_PI_Q30) begin
      z    = PI_Q30 - z;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z    = -PI_Q30 - z;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    if (flip) x = -x;
    cs = clamp_q14((x + 32768) >>> 16);
    sn = clamp_q14((y + 32768) >>> 16);
  endtask

  function automatic logic signed [15:0] round_q42(input longint v);
    return 16'(clamp_q14((v + (64'sd1 <<< 27)) >>> 28));
  endfunction

  task automatic predict_quat(input e2q_pkg::angles_t a, output e2q_pkg::quat_t q);
    longint s1, c1, s2, c2, s3, c3;
    half_angle_trig(a.roll_angle, s1, c1);
    half_angle_trig(a.pitch_angle, s2, c2);
    half_angle_trig(a.yaw_angle, s3, c3);
    q.quat_w = round_q42(c1 * c2 * c3 + s1 * s2 * s3);
    q.quat_x = round_q42(s1 * c2 * c3 - c1 * s2 * s3);
    q.quat_y = round_q42(c1 * s2 * c3 + s1 * c2 * s3);
    q.quat_z = round_q42(c1 * c2 * s3 - s1 * s2 * c3);
  endtask

  task automatic add_row(input int roll, input int pitch, input int yaw);
    stim_row_t r;
    r.ang.roll_angle  = 16'(roll);
    r.ang.pitch_angle = 16'(pitch);
    r.ang.yaw_angle   = 16'(yaw);
    r.typed           = 1'b0;
    r.quat            = '0;
    directed_rows.push_back(r);
  endtask

  function automatic logic signed [15:0] rand_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'(int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
    // hug the limits of the stated range, on both sides of it
    if (pick < 85) begin
      if ($urandom_range(1)) return 16'(ANGLE_MAX - 8 + int'($urandom_range(16)));
      return 16'(-ANGLE_MAX + 8 - int'($urandom_range(16)));
    end
    return 16'($urandom);
  endfunction

  task automatic offer_angles(input e2q_pkg::angles_t a, input logic typed,
                              input e2q_pkg::quat_t typed_q);
    e2q_pkg::quat_t q;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) q = typed_q;
    else predict_quat(a, q);
    quat_expect_q.push_back(q);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (quat_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [15:0] exp_v,
                             input logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // result monitor and output stall generator
  always @(posedge clk) begin
    e2q_pkg::quat_t exp_q;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatch_cnt++;
      end else begin
        exp_q = quat_expect_q.pop_front();
        check_field("quat_w", exp_q.quat_w, out_data.quat_w);
        check_field("quat_x", exp_q.quat_x, out_data.quat_x);
        check_field("quat_y", exp_q.quat_y, out_data.quat_y);
        check_field("quat_z", exp_q.quat_z, out_data.quat_z);
      end
    end
    if (hold_reqs != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t        row;
    e2q_pkg::angles_t a;
    e2q_pkg::quat_t   none_q;
    atan_tab = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };
    none_q = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;

    // zero rotation gives the identity quaternion
    add_row(0, 0, 0);
    directed_rows[0].typed       = 1'b1;
    directed_rows[0].quat.quat_w = 16'sd16384;
    add_row(ANGLE_MAX, 0, 0);
    add_row(-ANGLE_MAX, 0, 0);
    add_row(0, ANGLE_MAX, 0);
    add_row(0, -ANGLE_MAX, 0);
    add_row(0, 0, ANGLE_MAX);
    add_row(0, 0, -ANGLE_MAX);
    add_row(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
    add_row(-ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX);
    // just past pi: the half-angle needs folding
    add_row(ANGLE_MAX + 1, 0, 0);
    add_row(-ANGLE_MAX - 1, 0, 0);
    add_row(0, ANGLE_MAX + 4, -ANGLE_MAX - 4);
    // full 16-bit extremes, well outside the stated range
    add_row(32767, -32768, 0);
    add_row(-32768, 32767, 32767);
    add_row(32767, 32767, 32767);
    add_row(-32768, -32768, -32768);
    add_row(12868, 12868, 12868);
    add_row(-12868, 6434, -6434);
    add_row(1, -1, 1);
    add_row(-1, 1, -1);
    add_row(8192, -16384, 24576);
    add_row(21845, -21846, 10923);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_angles(row.ang, row.typed, row.quat);
    end
    drain_results();

    // long output hold-off: keep offering until the input stalls
    hold_reqs++;
    for (int n = 0; n < 60; n++) begin
      a.roll_angle  = rand_angle();
      a.pitch_angle = rand_angle();
      a.yaw_angle   = rand_angle();
      offer_angles(a, 1'b0, none_q);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
        default: begin src_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        a.roll_angle  = rand_angle();
        a.pitch_angle = rand_angle();
        a.yaw_angle   = rand_angle();
        offer_angles(a, 1'b0, none_q);
      end
      // pause the sender until the pipeline has emptied
      drain_results();
    end

    sink_stall_pct = 0;
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
